// ===== hdl/hjd_pkg.sv =====
// package: types and constants for the joypad descriptor parser
`default_nettype none
package hjd_pkg;
  localparam int UsageDepthDefault = 256;
  localparam logic [7:0] NotFound = 8'hff;
  localparam logic [7:0] UseX = 8'h30;
  localparam logic [7:0] UseY = 8'h31;
  localparam logic [7:0] UseHat = 8'h39;
  localparam logic [7:0] PageButton = 8'h09;
  localparam logic [7:0] CollLogical = 8'h02;
  localparam logic [1:0] TypeMain = 2'd0;
  localparam logic [1:0] TypeGlobal = 2'd1;
  localparam logic [1:0] TypeLocal = 2'd2;
  localparam logic [3:0] TagCollection = 4'hA;
  localparam logic [3:0] TagEndColl = 4'hC;
  localparam logic [3:0] TagPage = 4'h0;
  localparam logic [3:0] TagSize = 4'h7;
  localparam logic [3:0] TagId = 4'h8;
  localparam logic [3:0] TagCount = 4'h9;
  localparam logic [3:0] TagUsage = 4'h0;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] x_offset;
    logic [7:0] y_offset;
    logic [7:0] button_offset;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FINISH,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/hid_joypad_descriptor_parser.sv =====
// top level: byte-serial HID descriptor parser with usage memory
// a byte that closes a field group stalls the input while the parser walks
// its stored usages (a read and a check per stored usage) before finishing
// result word is registered: after a last byte the parser goes through the
// usage walk (if that byte closes a group) and the finish state, then offers it
// throughput: one byte per cycle outside group closes and results
// reset: synchronous active-low rst_n clears the FSM and parse tracking state
`default_nettype none
module hid_joypad_descriptor_parser #(
  parameter int USAGE_DEPTH = hjd_pkg::UsageDepthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hjd_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hjd_pkg::out_word_t     out_data
);
  import hjd_pkg::*;
  localparam int AW = $clog2(USAGE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [1:0] SetNone = 2'd0;
  localparam logic [1:0] SetSize = 2'd1;
  localparam logic [1:0] SetCount = 2'd2;

  // usage memory
  logic [7:0] mem [USAGE_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we;
  logic [7:0] mem_wd;
  logic [AW-1:0] mem_wa, mem_ra;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  state_t state_r, state_nxt;
  logic [7:0] prefix_r, prefix_nxt, first_r, first_nxt;
  logic [2:0] left_r, left_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt, idx_r, idx_nxt;
  logic [7:0] fsize_r, fsize_nxt, fcount_r, fcount_nxt, page_r, page_nxt;
  logic [7:0] chosen_r, chosen_nxt, pend_r, pend_nxt, lbytes_r, lbytes_nxt;
  logic [15:0] lbits_r, lbits_nxt, boff_r, boff_nxt;
  logic [7:0] xf_r, xf_nxt, yf_r, yf_nxt, bf_r, bf_nxt, bbits_r, bbits_nxt;
  logic [7:0] set_r, set_nxt;         // value set after close
  logic [1:0] setk_r, setk_nxt;       // which setting waits on the close
  logic       last_r, last_nxt;
  logic [15:0] prod_r, prod_nxt;
  out_word_t  out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; left_r <= '0; ucnt_r <= '0;
      fsize_r <= '0; fcount_r <= '0; page_r <= '0;
      chosen_r <= NotFound; pend_r <= NotFound; lbytes_r <= '0; lbits_r <= '0;
      xf_r <= NotFound; yf_r <= NotFound; bf_r <= NotFound; bbits_r <= '0;
      prefix_r <= '0; first_r <= '0;
    end else begin
      state_r <= state_nxt; left_r <= left_nxt; ucnt_r <= ucnt_nxt;
      fsize_r <= fsize_nxt; fcount_r <= fcount_nxt; page_r <= page_nxt;
      chosen_r <= chosen_nxt; pend_r <= pend_nxt; lbytes_r <= lbytes_nxt;
      lbits_r <= lbits_nxt; xf_r <= xf_nxt; yf_r <= yf_nxt; bf_r <= bf_nxt;
      bbits_r <= bbits_nxt; prefix_r <= prefix_nxt; first_r <= first_nxt;
    end
  end
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; set_r <= set_nxt; setk_r <= setk_nxt; last_r <= last_nxt;
    prod_r <= prod_nxt; boff_r <= boff_nxt; out_r <= out_nxt;
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;
  assign in_stall  = (state_r != ST_IDLE);

  logic [7:0] pfx, v;
  logic [2:0] dlen;
  logic       run;
  logic [3:0] tag;
  logic [1:0] typ;
  logic [7:0] pad_bytes;

  // true when the finished item closed a field group
  function automatic logic group_close(input logic [7:0] p, input logic [1:0] k,
                                       input logic [2:0] l);
    group_close = (l == 3'd0) && ((k != SetNone) ||
      (p[3:2] == TypeMain && p[7:4] == TagEndColl));
  endfunction

  always_comb begin
    state_nxt = state_r; left_nxt = left_r; ucnt_nxt = ucnt_r; idx_nxt = idx_r;
    fsize_nxt = fsize_r; fcount_nxt = fcount_r; page_nxt = page_r;
    chosen_nxt = chosen_r; pend_nxt = pend_r; lbytes_nxt = lbytes_r;
    lbits_nxt = lbits_r; xf_nxt = xf_r; yf_nxt = yf_r; bf_nxt = bf_r;
    bbits_nxt = bbits_r; prefix_nxt = prefix_r; first_nxt = first_r;
    set_nxt = set_r; setk_nxt = setk_r; last_nxt = last_r; prod_nxt = prod_r;
    boff_nxt = boff_r; out_nxt = out_r;
    mem_we = 1'b0; mem_wd = '0; mem_wa = ucnt_r[AW-1:0]; mem_ra = idx_r[AW-1:0];
    pfx = prefix_r; v = first_r; run = 1'b0; dlen = 3'd0;
    tag = '0; typ = '0; pad_bytes = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last_byte;
          setk_nxt = SetNone;
          // byte framing
          if (left_r == 3'd0) begin
            pfx = in_data.desc_byte; v = 8'd0;
            dlen = (pfx[1:0] == 2'd3) ? 3'd4 : {1'b0, pfx[1:0]};
            prefix_nxt = pfx; first_nxt = 8'd0; left_nxt = dlen;
            run = (dlen == 3'd0);
          end else begin
            dlen = (prefix_r[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_r[1:0]};
            if (left_r == dlen) begin
              v = in_data.desc_byte; first_nxt = v;
            end
            left_nxt = left_r - 3'd1;
            run = (left_r == 3'd1);
          end
          tag = pfx[7:4]; typ = pfx[3:2];
          prod_nxt = 16'(fcount_r) * 16'(fsize_r);
          boff_nxt = lbits_r; idx_nxt = '0;
          if (run) begin
            if (typ == TypeMain && tag == TagCollection) begin
              ucnt_nxt = '0; fcount_nxt = '0; fsize_nxt = '0;
              if (pfx[1:0] == 2'd1 && v == CollLogical) begin
                lbytes_nxt = '0; lbits_nxt = '0;
              end
            end else if (typ == TypeMain && tag == TagEndColl) begin
              state_nxt = ST_SCAN;
            end else if (typ == TypeGlobal && tag == TagPage) begin
              if (pfx[1:0] == 2'd1) page_nxt = v;
            end else if (typ == TypeGlobal && tag == TagSize) begin
              if (fsize_r != 0) begin
                state_nxt = ST_SCAN; setk_nxt = SetSize; set_nxt = v;
              end else fsize_nxt = v;
            end else if (typ == TypeGlobal && tag == TagCount) begin
              if (fcount_r != 0) begin
                state_nxt = ST_SCAN; setk_nxt = SetCount; set_nxt = v;
              end else fcount_nxt = v;
            end else if (typ == TypeGlobal && tag == TagId) begin
              pend_nxt = v;
            end else if (typ == TypeLocal && tag == TagUsage) begin
              if (ucnt_r < CW'(USAGE_DEPTH)) begin
                mem_we = 1'b1; mem_wd = v; ucnt_nxt = ucnt_r + 1'b1;
              end
            end
          end
          if (state_nxt == ST_IDLE && in_data.last_byte) state_nxt = ST_FINISH;
        end
      end
      // issue read of next usage
      ST_SCAN: begin
        if (idx_r == ucnt_r) state_nxt = ST_FINISH;
        else state_nxt = ST_SCAN_WAIT;
      end
      // check returned usage
      ST_SCAN_WAIT: begin
        if (fsize_r == 8'd8) begin
          if (rd_data_r == UseX && xf_r == NotFound)
            xf_nxt = lbytes_r + 8'(idx_r);
          else if (rd_data_r == UseY && yf_r == NotFound)
            yf_nxt = lbytes_r + 8'(idx_r);
        end else if (rd_data_r == UseHat && bf_r == NotFound) begin
          bf_nxt = boff_r[10:3]; bbits_nxt = fsize_r;
        end
        boff_nxt = boff_r + 16'(fsize_r);
        idx_nxt = idx_r + 1'b1;
        state_nxt = ST_SCAN;
      end
      // group close bookkeeping and/or result
      ST_FINISH: begin
        if (idx_r == ucnt_r && group_close(prefix_r, setk_r, left_r)) begin
          pad_bytes = 8'((17'(prod_r) + 17'd7) >> 3);
          if (page_r == PageButton && bf_r == NotFound) bf_nxt = lbytes_r;
          lbytes_nxt = lbytes_r + pad_bytes;
          lbits_nxt = lbits_r + prod_r;
          fcount_nxt = '0; fsize_nxt = '0; ucnt_nxt = '0;
          if (setk_r == SetSize) fsize_nxt = set_r;
          if (setk_r == SetCount) fcount_nxt = set_r;
          if (xf_r != NotFound && chosen_r == NotFound) chosen_nxt = pend_r;
          idx_nxt = '1;
        end
        if (last_r) begin
          out_nxt.x_offset = xf_r; out_nxt.y_offset = yf_r;
          out_nxt.button_offset = (group_close(prefix_r, setk_r, left_r)
            && idx_r == ucnt_r && page_r == PageButton && bf_r == NotFound)
            ? lbytes_r : bf_r;
          state_nxt = ST_OUT;
        end else state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        left_nxt = '0; ucnt_nxt = '0; fsize_nxt = '0; fcount_nxt = '0;
        page_nxt = '0; chosen_nxt = NotFound; pend_nxt = NotFound;
        lbytes_nxt = '0; lbits_nxt = '0; xf_nxt = NotFound; yf_nxt = NotFound;
        bf_nxt = NotFound; bbits_nxt = '0; prefix_nxt = '0; first_nxt = '0;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/hjd_checker.sv =====
// checker: port-level properties of the descriptor parser
`default_nettype none
module hjd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [23:0] out_data
);
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("hold");
  // no input taken while a result waits
  a_nin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("in while out");
  // a taken result word is not offered again
  a_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid) else $error("repeat");
endmodule
bind hid_joypad_descriptor_parser hjd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// ===== bench/hid_joypad_descriptor_parser_tb.sv =====
// testbench for the joypad descriptor parser: random and directed descriptors
`timescale 1ns / 100ps
`default_nettype none
module hid_joypad_descriptor_parser_tb;
  import hjd_pkg::*;

  // descriptor predictor and expected offset store
  class offset_board;
    logic [7:0] prefix, first_val, store[256];
    logic [2:0] remain;
    int unsigned n_use;
    logic [7:0] fsize, fcount, page, chosen, pending, len_bytes;
    logic [15:0] len_bits;
    logic [7:0] x_at, y_at, btn_at, btn_bits;
    out_word_t pending_offsets[$];
    int errors, n_checked;

    function void clear();
      remain = 0; prefix = 0; first_val = 0; n_use = 0; fsize = 0; fcount = 0;
      page = 0; chosen = NotFound; pending = NotFound; len_bytes = 0; len_bits = 0;
      x_at = NotFound; y_at = NotFound; btn_at = NotFound; btn_bits = 0;
    endfunction

    function logic [2:0] nbytes(logic [7:0] p);
      return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
    endfunction

    function void close_group();
      logic [31:0] prod;
      prod = fcount * fsize;
      for (int j = 0; j < n_use; j++) begin
        if (fsize == 8) begin
          if (store[j] == UseX && x_at == NotFound) x_at = 8'(len_bytes + j);
          else if (store[j] == UseY && y_at == NotFound) y_at = 8'(len_bytes + j);
        end else if (store[j] == UseHat && btn_at == NotFound) begin
          btn_at = 8'((32'(len_bits) + j * fsize) >> 3);
          btn_bits = fsize;
        end
      end
      if (page == PageButton && btn_at == NotFound) btn_at = len_bytes;
      len_bytes = len_bytes + 8'((prod + 7) >> 3);
      len_bits = len_bits + 16'(prod);
      fcount = 0; fsize = 0; n_use = 0;
      if (x_at != NotFound && chosen == NotFound) chosen = pending;
    endfunction

    function void run_item();
      logic [3:0] tag;
      logic [1:0] kind;
      tag = prefix[7:4];
      kind = prefix[3:2];
      if (kind == TypeMain) begin
        if (tag == TagCollection) begin
          n_use = 0; fcount = 0; fsize = 0;
          if (prefix[1:0] == 1 && first_val == CollLogical) begin
            len_bytes = 0; len_bits = 0;
          end
        end else if (tag == TagEndColl) close_group();
      end else if (kind == TypeGlobal) begin
        if (tag == TagPage) begin
          if (prefix[1:0] == 1) page = first_val;
        end else if (tag == TagSize) begin
          if (fsize != 0) close_group();
          fsize = first_val;
        end else if (tag == TagCount) begin
          if (fcount != 0) close_group();
          fcount = first_val;
        end else if (tag == TagId) pending = first_val;
      end else if (kind == TypeLocal) begin
        if (tag == TagUsage && n_use < 256) begin
          store[n_use] = first_val;
          n_use++;
        end
      end
    endfunction

    function void note_input(in_word_t w);
      if (remain == 0) begin
        prefix = w.desc_byte; first_val = 0; remain = nbytes(w.desc_byte);
        if (remain == 0) run_item();
      end else begin
        if (remain == nbytes(prefix)) first_val = w.desc_byte;
        remain--;
        if (remain == 0) run_item();
      end
      if (w.last_byte) begin
        pending_offsets.push_back('{x_at, y_at, btn_at});
        clear();
      end
    endfunction

    task check_result(out_word_t r);
      out_word_t e;
      n_checked++;
      if (pending_offsets.size() == 0) begin
        report("unexpected word", 0, r); return;
      end
      e = pending_offsets.pop_front();
      if (r.x_offset != e.x_offset) report("x_offset", e.x_offset, r.x_offset);
      if (r.y_offset != e.y_offset) report("y_offset", e.y_offset, r.y_offset);
      if (r.button_offset != e.button_offset)
        report("button_offset", e.button_offset, r.button_offset);
    endtask

    task report(string what, int e, int g);
      errors++;
      if (errors <= 40) $display("mismatch %s: expected %0d got %0d", what, e, g);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_word_t in_data = '0;
  out_word_t out_data;
  offset_board board = new();
  int cycles = 0, n_bytes = 0, hold_long = 0;
  bit held = 0;
  logic [7:0] desc_q[$];

  always #10 clk = ~clk;

  hid_joypad_descriptor_parser i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  // accept and check at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (cycles > 2000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_long > 0) begin
      out_stall <= 1;
      hold_long <= hold_long - 1;
    end else if (cycles % 300 < 100) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // one descriptor byte over the handshake, with burst gaps
  task automatic send_word(logic [7:0] b, logic fin);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{b, fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic add_item(logic [7:0] pfx, logic [7:0] val);
    desc_q.push_back(pfx);
    for (int k = 0; k < board.nbytes(pfx); k++)
      desc_q.push_back(k == 0 ? val : 8'($urandom));
  endtask

  // send the queued descriptor, marking the final byte
  task automatic send_desc();
    logic [7:0] b;
    while (desc_q.size() > 0) begin
      b = desc_q.pop_front();
      send_word(b, desc_q.size() == 0);
    end
    in_valid <= 0;
    @(negedge clk);
  endtask

  // joypad-like descriptor with random content, sometimes with a stray byte
  task automatic build_pad();
    int nf;
    add_item(8'h05, 8'h01);
    add_item(8'hA1, 8'($urandom_range(0, 3)));
    if ($urandom_range(0, 1)) add_item(8'h85, 8'($urandom));
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if ($urandom_range(0, 2) == 0) add_item(8'h05, $urandom_range(0, 1) ? PageButton : 8'h01);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 4))
          0: add_item(8'h09, UseX);
          1: add_item(8'h09, UseY);
          2: add_item(8'h09, UseHat);
          default: add_item(8'h08 | 8'($urandom_range(0, 3)), 8'($urandom));
        endcase
      end
      add_item(8'h75, $urandom_range(0, 1) ? 8'd8 : 8'($urandom_range(1, 16)));
      add_item(8'h95, 8'($urandom_range(1, 12)));
      add_item(8'h81, 8'h02);
    end
    if ($urandom_range(0, 3) == 0) desc_q.push_back(8'($urandom));
    add_item(8'hC0, 8'd0);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    // directed: extremes, size codes, logical collection, hat, button page
    add_item(8'h00, 8'd0); add_item(8'hFF, 8'hFF); send_desc();
    add_item(8'hA1, CollLogical); add_item(8'h09, UseX); add_item(8'h09, UseY);
    add_item(8'h75, 8'd8); add_item(8'h95, 8'd2); add_item(8'h05, PageButton);
    add_item(8'h09, UseHat); add_item(8'h77, 8'd4); add_item(8'h97, 8'd1);
    add_item(8'hC0, 8'd0); send_desc();
    add_item(8'h0B, 8'd1); add_item(8'hFE, 8'd3); send_desc();
    send_word(8'h76, 0); send_word(8'h08, 1);
    // store overflow: more usages than the store depth
    repeat (270) add_item(8'h09, UseX); add_item(8'h75, 8'd8); add_item(8'hC0, 8'd0);
    send_desc();
    // random descriptors, most well-formed, some noise
    while (n_bytes < 1800) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 20)) desc_q.push_back(8'($urandom));
      else build_pad();
      send_desc();
      if ($urandom_range(0, 30) == 0) begin
        while (board.pending_offsets.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
      end
      if (!held && n_bytes > 900) begin
        hold_long = 400;
        held = 1;
      end
    end
    while (board.pending_offsets.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("sent %0d descriptor bytes, checked %0d offset words", n_bytes,
             board.n_checked);
    if (board.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial board.clear();
endmodule
`default_nettype wire
